FILE: rtl/hyh_pkg.sv
// Shared types, constants and tables for the hadron yield histogrammer.
// Has no dependencies. Every other file in rtl/ uses it through scoped names.
package hyh_pkg;

  localparam int XB_BINS  = 9;
  localparam int SPECIES  = 4;
  localparam int Z_SLICES = 4;

  localparam int XB_EDGE_COUNT      = 10;
  localparam int Z_EDGE_COUNT       = 5;
  localparam int SPECIES_CODE_COUNT = 4;

  localparam int XB_USED = (XB_BINS < XB_EDGE_COUNT - 1) ? XB_BINS : XB_EDGE_COUNT - 1;
  localparam int Z_USED  = (Z_SLICES < Z_EDGE_COUNT - 1) ? Z_SLICES : Z_EDGE_COUNT - 1;
  localparam int SPECIES_USED = (SPECIES < SPECIES_CODE_COUNT) ? SPECIES : SPECIES_CODE_COUNT;

  localparam int SPEC_STRIDE = Z_SLICES * XB_BINS;
  localparam int HADRON_BINS = SPECIES * SPEC_STRIDE;
  localparam int TOTAL_BINS  = HADRON_BINS + XB_BINS;
  localparam int ADDR_W      = $clog2(TOTAL_BINS);
  localparam int IDX_W       = (ADDR_W > 8) ? ADDR_W : 8;

  localparam int XBIN_W  = 4;
  localparam int SPEC_W  = 2;
  localparam int SLICE_W = 2;
  localparam int EDGE_W  = 3;
  localparam int STEP_W  = 4;

  localparam int HDR_LAST = 3;
  localparam int PRT_LAST = 8;

  localparam logic [1:0] REG_MOM_MIN = 2'd0;
  localparam logic [1:0] REG_MOM_MAX = 2'd1;

  localparam logic [16:0] XB_EDGES [XB_EDGE_COUNT] = '{
    17'd1507, 17'd2621, 17'd3604, 17'd4915, 17'd6554,
    17'd9175, 17'd13107, 17'd19661, 17'd26214, 17'd39322
  };

  localparam logic [3:0] Z_TENTHS [Z_EDGE_COUNT] = '{4'd2, 4'd3, 4'd4, 4'd6, 4'd8};

  localparam logic signed [31:0] SPECIES_CODES [SPECIES_CODE_COUNT] = '{
    32'sd211, -32'sd211, 32'sd321, -32'sd321
  };

  typedef enum logic [1:0] {
    FUNC_HEADER   = 2'd0,
    FUNC_PARTICLE = 2'd1,
    FUNC_READ     = 2'd2,
    FUNC_NO_META  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_ZEDGE,
    ST_ZPICK
  } state_t;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_P2,
    TAG_LO2,
    TAG_HI2,
    TAG_PP,
    TAG_PQ
  } mac_tag_t;

  typedef struct packed {
    logic              valid;
    mac_op_t           op;
    mac_tag_t          tag;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mac_req_t;

  typedef struct packed {
    mac_tag_t           tag;
    logic signed [63:0] acc;
  } mac_rsp_t;

  typedef struct packed {
    logic             rd;
    logic             inc;
    logic [IDX_W-1:0] addr;
  } bin_req_t;

  typedef struct packed {
    logic clearing;
    logic wb_pending;
  } bin_sts_t;

endpackage

FILE: rtl/hyh_mac.sv
// Shared 32x32 signed multiplier followed by a 64-bit accumulator.
// The accumulator loads, adds without saturation, or subtracts with saturation. Depends on hyh_pkg.
module hyh_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  hyh_pkg::mac_req_t req,
  output hyh_pkg::mac_rsp_t rsp
);

  logic signed [63:0] prod_c;
  logic signed [63:0] prod_r;
  hyh_pkg::mac_op_t   op_r;
  logic               valid_p_r;
  hyh_pkg::mac_tag_t  tag_p_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] acc_nxt;
  hyh_pkg::mac_tag_t  tag_r;
  logic signed [64:0] diff;

  assign prod_c = req.a * req.b;
  assign diff   = {acc_r[63], acc_r} - {prod_r[63], prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (valid_p_r) begin
      case (op_r)
        hyh_pkg::MAC_LOAD: acc_nxt = prod_r;
        hyh_pkg::MAC_ADD:  acc_nxt = acc_r + prod_r;
        hyh_pkg::MAC_SUB: begin
          if (diff[64] != diff[63]) begin
            acc_nxt = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            acc_nxt = diff[63:0];
          end
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    op_r   <= req.op;
    acc_r  <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_p_r <= 1'b0;
      tag_p_r   <= hyh_pkg::TAG_NONE;
      tag_r     <= hyh_pkg::TAG_NONE;
    end else begin
      valid_p_r <= req.valid;
      tag_p_r   <= req.valid ? req.tag : hyh_pkg::TAG_NONE;
      tag_r     <= tag_p_r;
    end
  end

  assign rsp.tag = tag_r;
  assign rsp.acc = acc_r;

endmodule

FILE: rtl/hyh_bin_store.sv
// Histogram bin memory with one write port and one registered read port.
// It runs a clearing pass after reset and a saturating read-modify-write. Depends on hyh_pkg.
module hyh_bin_store (
  input  logic              clk,
  input  logic              rst_n,
  input  hyh_pkg::bin_req_t req,
  output hyh_pkg::bin_sts_t sts,
  output logic              rsp_valid,
  output logic [31:0]       rsp_data
);

  logic [31:0] mem [hyh_pkg::TOTAL_BINS];

  logic                       clearing_r;
  logic [hyh_pkg::ADDR_W-1:0] clr_addr_r;
  logic                       wb_r;
  logic                       rsp_valid_r;
  logic [hyh_pkg::ADDR_W-1:0] wb_addr_r;
  logic [31:0]                q_r;
  logic                       zero_r;
  logic                       in_range;
  logic [31:0]                wdata;

  assign in_range = req.addr < hyh_pkg::IDX_W'(hyh_pkg::TOTAL_BINS);
  assign wdata    = (q_r == '1) ? q_r : q_r + 32'd1;

  always_ff @(posedge clk) begin
    if (req.rd || req.inc) begin
      q_r <= mem[req.addr[hyh_pkg::ADDR_W-1:0]];
    end
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wb_r) begin
      mem[wb_addr_r] <= wdata;
    end
    wb_addr_r <= req.addr[hyh_pkg::ADDR_W-1:0];
    zero_r    <= !in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      wb_r        <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        if (clr_addr_r == hyh_pkg::ADDR_W'(hyh_pkg::TOTAL_BINS - 1)) begin
          clearing_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      wb_r        <= req.inc && in_range;
      rsp_valid_r <= req.rd;
    end
  end

  assign sts.clearing   = clearing_r;
  assign sts.wb_pending = wb_r;
  assign rsp_valid      = rsp_valid_r;
  assign rsp_data       = zero_r ? 32'd0 : q_r;

endmodule

FILE: rtl/hadron_yield_histogrammer.sv
// Top level of the hadron yield histogrammer. Instantiates hyh_mac and hyh_bin_store and uses hyh_pkg.
// After reset, busy stays high during a clearing pass over the bin memory. The bin_count of an
// accepted read item appears on the next cycle for one cycle under out_valid.
// The receiver cannot hold a result off. A header's dot product runs as four
// issues through the single shared multiplier and its two-stage accumulator, and its DIS count
// overlaps that work. An event without metadata, or a particle that is dropped on species or
// arming, leaves the block idle. A particle that is dropped on the momentum cut or on a zero P.q
// goes back to idle from the check state. A particle that is evaluated up to the z slices ends in
// the pick state and writes a bin back when it counts, after nine multiplier issues (three squares,
// both cut squares, and P.p) and one edge compare per cycle over the five slice edges.
module hadron_yield_histogrammer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_pdg_id,
  input  logic signed [31:0] in_mom_energy,
  input  logic signed [31:0] in_mom_x,
  input  logic signed [31:0] in_mom_y,
  input  logic signed [31:0] in_mom_z,
  input  logic [16:0]        in_xb_value,
  input  logic signed [31:0] in_photon_energy,
  input  logic signed [31:0] in_photon_x,
  input  logic signed [31:0] in_photon_y,
  input  logic signed [31:0] in_photon_z,
  input  logic [7:0]         in_read_index,
  output logic               out_valid,
  output logic [31:0]        out_bin_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  hyh_pkg::state_t state_r, state_nxt;

  hyh_pkg::mac_req_t mac_req;
  hyh_pkg::mac_rsp_t mac_rsp;
  hyh_pkg::bin_req_t bin_req;
  hyh_pkg::bin_sts_t bin_sts;

  logic [hyh_pkg::STEP_W-1:0]  step_r;
  logic [hyh_pkg::STEP_W-1:0]  step_end;
  logic [hyh_pkg::STEP_W-1:0]  step_last;
  logic [hyh_pkg::EDGE_W-1:0]  edge_r;
  logic                        armed_r;
  logic [hyh_pkg::XBIN_W-1:0]  xbin_r;
  hyh_pkg::func_t              func_r;
  logic [hyh_pkg::SPEC_W-1:0]  species_r;
  logic signed [31:0]          tgt_r [4];
  logic signed [63:0]          pq_r;
  logic [30:0]                 mom_min_r;
  logic [30:0]                 mom_max_r;

  logic signed [31:0]          vec_r [4];
  logic signed [31:0]          phot_r [4];
  logic [63:0]                 p2_r;
  logic [63:0]                 lo2_r;
  logic [63:0]                 hi2_r;
  logic signed [63:0]          pp_r;
  logic signed [67:0]          ten_pp_r;
  logic [hyh_pkg::Z_EDGE_COUNT-1:0] above_r;
  logic [hyh_pkg::Z_EDGE_COUNT-1:0] below_r;

  logic                        accept;
  hyh_pkg::func_t              in_func_e;
  logic                        xb_found;
  logic [hyh_pkg::XBIN_W-1:0]  xb_idx;
  logic                        sp_found;
  logic [hyh_pkg::SPEC_W-1:0]  sp_idx;
  logic                        sp_ok;
  logic                        cut_fail;
  logic signed [67:0]          pp_ext;
  logic signed [67:0]          pq_ext;
  logic signed [67:0]          tpq;
  logic [3:0]                  t_cur;
  logic                        gt;
  logic                        lt;
  logic                        slice_found;
  logic [hyh_pkg::SLICE_W-1:0] slice_idx;
  logic [hyh_pkg::IDX_W-1:0]   hadron_addr;

  hyh_mac u_mac (
    .clk (clk),
    .rst_n (rst_n),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  hyh_bin_store u_store (
    .clk (clk),
    .rst_n (rst_n),
    .req (bin_req),
    .sts (bin_sts),
    .rsp_valid (out_valid),
    .rsp_data (out_bin_count)
  );

  assign in_func_e = hyh_pkg::func_t'(in_func);
  assign busy      = (state_r != hyh_pkg::ST_IDLE) || bin_sts.clearing || bin_sts.wb_pending;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    xb_found = 1'b0;
    xb_idx   = '0;
    for (int i = 0; i < hyh_pkg::XB_USED; i++) begin
      if (!xb_found && in_xb_value >= hyh_pkg::XB_EDGES[i] &&
          in_xb_value < hyh_pkg::XB_EDGES[i+1]) begin
        xb_found = 1'b1;
        xb_idx   = hyh_pkg::XBIN_W'(i);
      end
    end
  end

  always_comb begin
    sp_found = 1'b0;
    sp_idx   = '0;
    for (int k = 0; k < hyh_pkg::SPECIES_CODE_COUNT; k++) begin
      if (!sp_found && in_pdg_id == hyh_pkg::SPECIES_CODES[k]) begin
        sp_found = 1'b1;
        sp_idx   = hyh_pkg::SPEC_W'(k);
      end
    end
  end

  assign sp_ok = sp_found && ({1'b0, sp_idx} < 3'(hyh_pkg::SPECIES_USED));

  assign step_last = (func_r == hyh_pkg::FUNC_HEADER) ? hyh_pkg::STEP_W'(hyh_pkg::HDR_LAST)
                                                     : hyh_pkg::STEP_W'(hyh_pkg::PRT_LAST);
  assign step_end  = step_last + hyh_pkg::STEP_W'(2);

  assign cut_fail = (p2_r < lo2_r) || (p2_r > hi2_r) || (pq_r == 64'sd0);

  assign pp_ext = {{4{pp_r[63]}}, pp_r};
  assign pq_ext = {{4{pq_r[63]}}, pq_r};
  assign t_cur  = hyh_pkg::Z_TENTHS[edge_r];
  assign tpq    = pq_ext * $signed({1'b0, t_cur});
  assign gt     = ten_pp_r > tpq;
  assign lt     = ten_pp_r < tpq;

  always_comb begin
    slice_found = 1'b0;
    slice_idx   = '0;
    for (int s = 0; s < hyh_pkg::Z_USED; s++) begin
      if (!slice_found && above_r[s] && below_r[s+1]) begin
        slice_found = 1'b1;
        slice_idx   = hyh_pkg::SLICE_W'(s);
      end
    end
  end

  assign hadron_addr = hyh_pkg::IDX_W'(species_r) * hyh_pkg::IDX_W'(hyh_pkg::SPEC_STRIDE)
                     + hyh_pkg::IDX_W'(slice_idx) * hyh_pkg::IDX_W'(hyh_pkg::XB_BINS)
                     + hyh_pkg::IDX_W'(xbin_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hyh_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func_e)
            hyh_pkg::FUNC_HEADER:   state_nxt = hyh_pkg::ST_MUL;
            hyh_pkg::FUNC_PARTICLE: begin
              if (armed_r && sp_ok) begin
                state_nxt = hyh_pkg::ST_MUL;
              end
            end
            default: state_nxt = hyh_pkg::ST_IDLE;
          endcase
        end
      end
      hyh_pkg::ST_MUL: begin
        if (step_r == step_end) begin
          state_nxt = (func_r == hyh_pkg::FUNC_HEADER) ? hyh_pkg::ST_IDLE : hyh_pkg::ST_CHECK;
        end
      end
      hyh_pkg::ST_CHECK: state_nxt = cut_fail ? hyh_pkg::ST_IDLE : hyh_pkg::ST_ZEDGE;
      hyh_pkg::ST_ZEDGE: begin
        if (edge_r == hyh_pkg::EDGE_W'(hyh_pkg::Z_USED)) begin
          state_nxt = hyh_pkg::ST_ZPICK;
        end
      end
      hyh_pkg::ST_ZPICK: state_nxt = hyh_pkg::ST_IDLE;
      default:           state_nxt = hyh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mac_req = '0;
    bin_req = '0;
    case (state_r)
      hyh_pkg::ST_IDLE: begin
        if (accept && in_func_e == hyh_pkg::FUNC_READ) begin
          bin_req.rd   = 1'b1;
          bin_req.addr = hyh_pkg::IDX_W'(in_read_index);
        end else if (accept && in_func_e == hyh_pkg::FUNC_HEADER && xb_found) begin
          bin_req.inc  = 1'b1;
          bin_req.addr = hyh_pkg::IDX_W'(hyh_pkg::HADRON_BINS) + hyh_pkg::IDX_W'(xb_idx);
        end
      end
      hyh_pkg::ST_MUL: begin
        if (step_r <= step_last) begin
          mac_req.valid = 1'b1;
          if (func_r == hyh_pkg::FUNC_HEADER) begin
            mac_req.a   = tgt_r[step_r[1:0]];
            mac_req.b   = phot_r[step_r[1:0]];
            mac_req.op  = (step_r == '0) ? hyh_pkg::MAC_LOAD : hyh_pkg::MAC_SUB;
            mac_req.tag = (step_r == step_last) ? hyh_pkg::TAG_PQ : hyh_pkg::TAG_NONE;
          end else begin
            case (step_r)
              4'd0: begin
                mac_req.a = vec_r[1]; mac_req.b = vec_r[1];
                mac_req.op = hyh_pkg::MAC_LOAD; mac_req.tag = hyh_pkg::TAG_NONE;
              end
              4'd1: begin
                mac_req.a = vec_r[2]; mac_req.b = vec_r[2];
                mac_req.op = hyh_pkg::MAC_ADD; mac_req.tag = hyh_pkg::TAG_NONE;
              end
              4'd2: begin
                mac_req.a = vec_r[3]; mac_req.b = vec_r[3];
                mac_req.op = hyh_pkg::MAC_ADD; mac_req.tag = hyh_pkg::TAG_P2;
              end
              4'd3: begin
                mac_req.a = {1'b0, mom_min_r}; mac_req.b = {1'b0, mom_min_r};
                mac_req.op = hyh_pkg::MAC_LOAD; mac_req.tag = hyh_pkg::TAG_LO2;
              end
              4'd4: begin
                mac_req.a = {1'b0, mom_max_r}; mac_req.b = {1'b0, mom_max_r};
                mac_req.op = hyh_pkg::MAC_LOAD; mac_req.tag = hyh_pkg::TAG_HI2;
              end
              4'd5: begin
                mac_req.a = tgt_r[0]; mac_req.b = vec_r[0];
                mac_req.op = hyh_pkg::MAC_LOAD; mac_req.tag = hyh_pkg::TAG_NONE;
              end
              4'd6: begin
                mac_req.a = tgt_r[1]; mac_req.b = vec_r[1];
                mac_req.op = hyh_pkg::MAC_SUB; mac_req.tag = hyh_pkg::TAG_NONE;
              end
              4'd7: begin
                mac_req.a = tgt_r[2]; mac_req.b = vec_r[2];
                mac_req.op = hyh_pkg::MAC_SUB; mac_req.tag = hyh_pkg::TAG_NONE;
              end
              default: begin
                mac_req.a = tgt_r[3]; mac_req.b = vec_r[3];
                mac_req.op = hyh_pkg::MAC_SUB; mac_req.tag = hyh_pkg::TAG_PP;
              end
            endcase
          end
        end
      end
      hyh_pkg::ST_ZPICK: begin
        if (slice_found) begin
          bin_req.inc  = 1'b1;
          bin_req.addr = hadron_addr;
        end
      end
      default: begin
        mac_req = '0;
        bin_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vec_r[0]  <= in_mom_energy;
      vec_r[1]  <= in_mom_x;
      vec_r[2]  <= in_mom_y;
      vec_r[3]  <= in_mom_z;
      phot_r[0] <= in_photon_energy;
      phot_r[1] <= in_photon_x;
      phot_r[2] <= in_photon_y;
      phot_r[3] <= in_photon_z;
    end
    case (mac_rsp.tag)
      hyh_pkg::TAG_P2:  p2_r  <= mac_rsp.acc;
      hyh_pkg::TAG_LO2: lo2_r <= mac_rsp.acc;
      hyh_pkg::TAG_HI2: hi2_r <= mac_rsp.acc;
      hyh_pkg::TAG_PP:  pp_r  <= mac_rsp.acc;
      default: ;
    endcase
    if (state_r == hyh_pkg::ST_CHECK) begin
      ten_pp_r <= (pp_ext <<< 3) + (pp_ext <<< 1);
    end
    if (state_r == hyh_pkg::ST_ZEDGE) begin
      above_r[edge_r] <= pq_r[63] ? lt : gt;
      below_r[edge_r] <= pq_r[63] ? gt : lt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hyh_pkg::ST_IDLE;
      step_r    <= '0;
      edge_r    <= '0;
      armed_r   <= 1'b0;
      xbin_r    <= '0;
      func_r    <= hyh_pkg::FUNC_HEADER;
      species_r <= '0;
      for (int k = 0; k < 4; k++) begin
        tgt_r[k] <= '0;
      end
      pq_r      <= '0;
      mom_min_r <= 31'd131072;
      mom_max_r <= 31'd983040;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        func_r    <= in_func_e;
        species_r <= sp_idx;
        step_r    <= '0;
        case (in_func_e)
          hyh_pkg::FUNC_HEADER: begin
            tgt_r[0] <= in_mom_energy;
            tgt_r[1] <= in_mom_x;
            tgt_r[2] <= in_mom_y;
            tgt_r[3] <= in_mom_z;
            armed_r  <= xb_found;
            xbin_r   <= xb_idx;
          end
          hyh_pkg::FUNC_NO_META: armed_r <= 1'b0;
          default: ;
        endcase
      end else if (state_r == hyh_pkg::ST_MUL) begin
        step_r <= step_r + 1'b1;
      end
      if (mac_rsp.tag == hyh_pkg::TAG_PQ) begin
        pq_r <= mac_rsp.acc;
      end
      if (state_r == hyh_pkg::ST_CHECK) begin
        edge_r <= '0;
      end else if (state_r == hyh_pkg::ST_ZEDGE) begin
        edge_r <= edge_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hyh_pkg::REG_MOM_MIN: mom_min_r <= cfg_data;
          hyh_pkg::REG_MOM_MAX: mom_max_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: dv/hyh_yield_checker.sv
// Checker for the hadron yield histogrammer: predicts every bin read and compares each out beat.
// Watches the item, result and register channels of the block; uses constants from hyh_pkg.
// Hands the mismatch count and the number of outstanding reads to the testbench top.
module hyh_yield_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_pdg_id,
  input  logic signed [31:0] in_mom_energy,
  input  logic signed [31:0] in_mom_x,
  input  logic signed [31:0] in_mom_y,
  input  logic signed [31:0] in_mom_z,
  input  logic [16:0]        in_xb_value,
  input  logic signed [31:0] in_photon_energy,
  input  logic signed [31:0] in_photon_x,
  input  logic signed [31:0] in_photon_y,
  input  logic signed [31:0] in_photon_z,
  input  logic [7:0]         in_read_index,
  input  logic               out_valid,
  input  logic [31:0]        out_bin_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_XB      = 9;
  localparam int N_SLICE   = 4;
  localparam int BIN_TOTAL = 153;
  localparam int DIS_BASE  = 144;
  localparam int SPEC_SPAN = 36;

  localparam logic [16:0] X_EDGE [10] = '{
    17'd1507, 17'd2621, 17'd3604, 17'd4915, 17'd6554,
    17'd9175, 17'd13107, 17'd19661, 17'd26214, 17'd39322
  };
  localparam int Z_TENTH [5] = '{2, 3, 4, 6, 8};

  typedef logic signed [31:0] vec4_t [4];

  logic [31:0]        hist [BIN_TOTAL];
  logic               armed;
  logic [3:0]         cur_xbin;
  vec4_t              tgt;
  logic signed [63:0] tgt_dot_q;
  logic [30:0]        p_min;
  logic [30:0]        p_max;
  logic [31:0]        bin_counts_due [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] minkowski(input vec4_t a, input vec4_t b);
    logic signed [63:0] acc;
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = a[0];
    eb = b[0];
    acc = ea * eb;
    for (int k = 1; k < 4; k++) begin
      ea = a[k];
      eb = b[k];
      acc = sat_sum(acc, -(ea * eb));
    end
    return acc;
  endfunction

  function automatic int z_slice(input logic signed [63:0] pp, input logic signed [63:0] pq);
    logic signed [71:0] lhs;
    logic signed [71:0] lo_r;
    logic signed [71:0] hi_r;
    logic signed [71:0] wq;
    lhs = pp;
    lhs = lhs * 10;
    wq = pq;
    for (int s = 0; s < N_SLICE; s++) begin
      lo_r = wq * Z_TENTH[s];
      hi_r = wq * Z_TENTH[s + 1];
      if (pq > 0 ? (lhs > lo_r && lhs < hi_r) : (lhs < lo_r && lhs > hi_r)) return s;
    end
    return -1;
  endfunction

  task automatic bump(input int idx);
    if (hist[idx] != 32'hFFFF_FFFF) hist[idx] = hist[idx] + 32'd1;
  endtask

  task automatic reset_model();
    for (int i = 0; i < BIN_TOTAL; i++) hist[i] = '0;
    armed = 1'b0;
    cur_xbin = '0;
    tgt = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
    tgt_dot_q = '0;
    p_min = 31'd131072;
    p_max = 31'd983040;
    bin_counts_due.delete();
  endtask

  task automatic update_histogram();
    vec4_t              q;
    vec4_t              h;
    logic signed [63:0] e;
    logic signed [63:0] pp;
    longint unsigned    p2;
    longint unsigned    m;
    longint unsigned    lo2;
    longint unsigned    hi2;
    int                 sp;
    int                 sl;
    logic [31:0]        due;
    case (in_func)
      hyh_pkg::FUNC_HEADER: begin
        tgt = '{in_mom_energy, in_mom_x, in_mom_y, in_mom_z};
        q = '{in_photon_energy, in_photon_x, in_photon_y, in_photon_z};
        tgt_dot_q = minkowski(tgt, q);
        armed = 1'b0;
        cur_xbin = '0;
        for (int i = 0; i < N_XB; i++) begin
          if (!armed && in_xb_value >= X_EDGE[i] && in_xb_value < X_EDGE[i + 1]) begin
            armed = 1'b1;
            cur_xbin = 4'(i);
            bump(DIS_BASE + i);
          end
        end
      end
      hyh_pkg::FUNC_PARTICLE: begin
        case (in_pdg_id)
          32'sd211:  sp = 0;
          -32'sd211: sp = 1;
          32'sd321:  sp = 2;
          -32'sd321: sp = 3;
          default:   sp = -1;
        endcase
        if (armed && sp >= 0) begin
          h = '{in_mom_energy, in_mom_x, in_mom_y, in_mom_z};
          p2 = 0;
          for (int k = 1; k < 4; k++) begin
            e = h[k];
            m = (e < 0) ? -e : e;
            p2 += m * m;
          end
          m = p_min;
          lo2 = m * m;
          m = p_max;
          hi2 = m * m;
          if (p2 >= lo2 && p2 <= hi2 && tgt_dot_q != 0) begin
            pp = minkowski(tgt, h);
            sl = z_slice(pp, tgt_dot_q);
            if (sl >= 0) bump(sp * SPEC_SPAN + sl * N_XB + int'(cur_xbin));
          end
        end
      end
      hyh_pkg::FUNC_READ: begin
        due = (in_read_index < BIN_TOTAL) ? hist[in_read_index] : 32'd0;
        bin_counts_due = {bin_counts_due, due};
      end
      default: armed = 1'b0;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_valid === 1'b1) begin
        if (bin_counts_due.size() == 0) begin
          report_mismatch($sformatf("out beat with no read outstanding, bin_count %0d",
                                    out_bin_count));
        end else if (out_bin_count !== bin_counts_due[0]) begin
          report_mismatch($sformatf("bin_count got %0d expected %0d",
                                    out_bin_count, bin_counts_due[0]));
          void'(bin_counts_due.pop_front());
        end else begin
          void'(bin_counts_due.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hyh_pkg::REG_MOM_MIN: p_min = cfg_data;
          hyh_pkg::REG_MOM_MAX: p_max = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) update_histogram();
    end
    outstanding = bin_counts_due.size();
  end

endmodule

FILE: dv/hadron_yield_histogrammer_tb.sv
// Testbench top for the hadron yield histogrammer: directed and random event streams,
// momentum-cut register phases and a final sweep over every bin.
// Instantiates the block and hyh_yield_checker; uses constants from hyh_pkg.
module hadron_yield_histogrammer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GEV  = 65536;
  localparam int MASS = 61472;
  localparam int HADRON_CODES [4] = '{211, -211, 321, -321};
  localparam int SLICE_TENTHS [5] = '{2, 3, 4, 6, 8};

  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] pdg;
    logic signed [31:0] me;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic [16:0]        xb;
    logic signed [31:0] qe;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic [7:0]         ridx;
  } item_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_func;
  logic signed [31:0] in_pdg_id;
  logic signed [31:0] in_mom_energy;
  logic signed [31:0] in_mom_x;
  logic signed [31:0] in_mom_y;
  logic signed [31:0] in_mom_z;
  logic [16:0]        in_xb_value;
  logic signed [31:0] in_photon_energy;
  logic signed [31:0] in_photon_x;
  logic signed [31:0] in_photon_y;
  logic signed [31:0] in_photon_z;
  logic [7:0]         in_read_index;
  logic               out_valid;
  logic [31:0]        out_bin_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [30:0]        cfg_data;
  int                 mismatches;
  int                 outstanding;
  int                 items_sent = 0;
  bit                 no_idle = 1'b0;

  hadron_yield_histogrammer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_pdg_id        (in_pdg_id),
    .in_mom_energy    (in_mom_energy),
    .in_mom_x         (in_mom_x),
    .in_mom_y         (in_mom_y),
    .in_mom_z         (in_mom_z),
    .in_xb_value      (in_xb_value),
    .in_photon_energy (in_photon_energy),
    .in_photon_x      (in_photon_x),
    .in_photon_y      (in_photon_y),
    .in_photon_z      (in_photon_z),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_bin_count    (out_bin_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  hyh_yield_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_pdg_id        (in_pdg_id),
    .in_mom_energy    (in_mom_energy),
    .in_mom_x         (in_mom_x),
    .in_mom_y         (in_mom_y),
    .in_mom_z         (in_mom_z),
    .in_xb_value      (in_xb_value),
    .in_photon_energy (in_photon_energy),
    .in_photon_x      (in_photon_x),
    .in_photon_y      (in_photon_y),
    .in_photon_z      (in_photon_z),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_bin_count    (out_bin_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("hadron_yield_histogrammer regression: fail");
    $finish;
  end

  function automatic int srand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.func = 2'($urandom());
    it.pdg  = $urandom();
    it.me   = $urandom();
    it.mx   = $urandom();
    it.my   = $urandom();
    it.mz   = $urandom();
    it.xb   = 17'($urandom_range(0, 65536));
    it.qe   = $urandom();
    it.qx   = $urandom();
    it.qy   = $urandom();
    it.qz   = $urandom();
    it.ridx = 8'($urandom());
    return it;
  endfunction

  task automatic push_item(input item_t it);
    int n;
    @(negedge clk);
    start            <= 1'b1;
    in_func          <= it.func;
    in_pdg_id        <= it.pdg;
    in_mom_energy    <= it.me;
    in_mom_x         <= it.mx;
    in_mom_y         <= it.my;
    in_mom_z         <= it.mz;
    in_xb_value      <= it.xb;
    in_photon_energy <= it.qe;
    in_photon_x      <= it.qx;
    in_photon_y      <= it.qy;
    in_photon_z      <= it.qz;
    in_read_index    <= it.ridx;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic header(input int xb, input int te, input int tx, input int ty, input int tz,
                        input int qe, input int qx, input int qy, input int qz);
    item_t it;
    it = noise_item();
    it.func = hyh_pkg::FUNC_HEADER;
    it.xb = 17'(xb);
    it.me = te;
    it.mx = tx;
    it.my = ty;
    it.mz = tz;
    it.qe = qe;
    it.qx = qx;
    it.qy = qy;
    it.qz = qz;
    push_item(it);
  endtask

  task automatic particle(input int pdg, input int e, input int px, input int py, input int pz);
    item_t it;
    it = noise_item();
    it.func = hyh_pkg::FUNC_PARTICLE;
    it.pdg = pdg;
    it.me = e;
    it.mx = px;
    it.my = py;
    it.mz = pz;
    push_item(it);
  endtask

  task automatic read_bin(input int idx);
    item_t it;
    it = noise_item();
    it.func = hyh_pkg::FUNC_READ;
    it.ridx = 8'(idx);
    push_item(it);
  endtask

  task automatic no_meta();
    item_t it;
    it = noise_item();
    it.func = hyh_pkg::FUNC_NO_META;
    push_item(it);
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 9) == 0) read_bin($urandom_range(153, 255));
      else read_bin($urandom_range(0, 152));
    end
  endtask

  task automatic random_particle(input int nu);
    int pick;
    int pdg;
    int e;
    pick = $urandom_range(0, 99);
    if (pick < 85) pdg = HADRON_CODES[$urandom_range(0, 3)];
    else if (pick < 93) pdg = srand(400);
    else pdg = $urandom();
    pick = $urandom_range(0, 9);
    if (pick == 0) e = (nu / 10) * SLICE_TENTHS[$urandom_range(0, 4)];
    else if (pick == 1) e = $urandom();
    else e = $urandom_range(0, nu);
    if ($urandom_range(0, 19) == 0)
      particle(pdg, e, $urandom(), $urandom(), $urandom());
    else
      particle(pdg, e, srand(2 * GEV), srand(2 * GEV), srand(18 * GEV));
  endtask

  task automatic random_event();
    int r;
    int nu;
    int te;
    int tx;
    int ty;
    int tz;
    int xb;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      no_meta();
    end else if (r < 12) begin
      header($urandom_range(0, 65536), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      nu = 10 * int'($urandom_range(6554, 131072));
      te = (r < 18) ? -MASS : MASS + srand(1000);
      tx = 0;
      ty = 0;
      tz = 0;
      if ($urandom_range(0, 3) == 0) begin
        tx = srand(GEV);
        ty = srand(GEV);
        tz = srand(GEV);
      end
      xb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65536) : $urandom_range(1507, 39321);
      if (r < 21) header(xb, te, tx, ty, tz, 0, 0, 0, 0);
      else header(xb, te, tx, ty, tz, nu, srand(GEV / 2), srand(GEV / 2), nu + srand(GEV));
      repeat ($urandom_range(0, 8)) begin
        random_particle(nu);
        maybe_read();
      end
    end
    maybe_read();
  endtask

  task automatic quiesce();
    int n;
    @(negedge clk);
    start <= 1'b0;
    for (n = 0; n < 4000 && (busy !== 1'b0 || outstanding != 0); n++) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int stop_at;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = hyh_pkg::FUNC_HEADER;
    in_pdg_id = '0;
    in_mom_energy = '0;
    in_mom_x = '0;
    in_mom_y = '0;
    in_mom_z = '0;
    in_xb_value = '0;
    in_photon_energy = '0;
    in_photon_x = '0;
    in_photon_y = '0;
    in_photon_z = '0;
    in_read_index = '0;
    cfg_valid = 1'b0;
    cfg_index = hyh_pkg::REG_MOM_MIN;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    read_bin(0);
    read_bin(152);
    read_bin(200);
    header(1507, MASS, 0, 0, 0, 10 * GEV, 0, 0, 10 * GEV);
    particle(211, 163840, 0, 0, 3 * GEV);
    particle(-211, 3 * GEV, 0, 0, 3 * GEV);
    particle(321, 294912, 0, 0, 2 * GEV);
    particle(-321, 7 * GEV, 0, 0, 15 * GEV);
    particle(211, 163840, 0, 0, 2 * GEV - 1);
    particle(211, 163840, 15 * GEV, 1, 0);
    particle(111, 163840, 0, 0, 3 * GEV);
    particle(32'sh8000_0000, 163840, 0, 0, 3 * GEV);
    particle(211, 9 * GEV, 0, 0, 3 * GEV);
    read_bin(0);
    no_meta();
    particle(211, 163840, 0, 0, 3 * GEV);
    header(39321, MASS, 0, 0, 0, 10 * GEV, 0, 0, 10 * GEV);
    header(39322, MASS, 0, 0, 0, 10 * GEV, 0, 0, 10 * GEV);
    particle(211, 163840, 0, 0, 3 * GEV);
    header(0, MASS, 0, 0, 0, 10 * GEV, 0, 0, 10 * GEV);
    header(65536, MASS, 0, 0, 0, 10 * GEV, 0, 0, 10 * GEV);
    header(1507, MASS, 0, 0, 0, 0, 0, 0, 0);
    particle(211, 163840, 0, 0, 3 * GEV);
    header(4915, -MASS, 0, 0, 0, 10 * GEV, 0, 0, 10 * GEV);
    particle(-211, 163840, 0, 0, 3 * GEV);
    header(2621, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
           32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    particle(321, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    read_bin(144);

    for (phase = 0; phase < 6; phase++) begin
      quiesce();
      case (phase)
        1: begin
          write_reg(hyh_pkg::REG_MOM_MIN, 31'd0);
          write_reg(hyh_pkg::REG_MOM_MAX, 31'h7FFF_FFFF);
        end
        2: begin
          write_reg(hyh_pkg::REG_MOM_MIN, 31'(5 * GEV));
          write_reg(hyh_pkg::REG_MOM_MAX, 31'(5 * GEV));
        end
        3: begin
          write_reg(hyh_pkg::REG_MOM_MIN, 31'(15 * GEV));
          write_reg(hyh_pkg::REG_MOM_MAX, 31'(2 * GEV));
        end
        4: begin
          write_reg(hyh_pkg::REG_MOM_MIN, 31'($urandom()));
          write_reg(hyh_pkg::REG_MOM_MAX, 31'($urandom()));
          write_reg(2'd2, 31'($urandom()));
          write_reg(2'd3, 31'($urandom()));
        end
        5: begin
          write_reg(hyh_pkg::REG_MOM_MIN, 31'($urandom_range(0, 4 * GEV)));
          write_reg(hyh_pkg::REG_MOM_MAX, 31'($urandom_range(5 * GEV, 25 * GEV)));
        end
        default: ;
      endcase
      no_idle = (phase == 2);
      stop_at = items_sent + 260;
      while (items_sent < stop_at) random_event();
    end

    quiesce();
    no_idle = 1'b0;
    for (int i = 0; i < 153; i++) read_bin(i);
    quiesce();
    if (mismatches == 0 && outstanding == 0) begin
      $display("hadron_yield_histogrammer regression: pass");
    end else begin
      $display("hadron_yield_histogrammer regression: fail");
    end
    $finish;
  end

endmodule
